// File: rtl/core/trd_pkg.sv
`default_nettype none

package trd_pkg;

	// Size of the framed-block table and the width of its address.
	localparam int BLOCK_TYPES = 1024;
	localparam int TBL_AW      = $clog2(BLOCK_TYPES);

	// Header word layout.
	localparam logic [15:0] HDR_COUNT_MASK = 16'h0fff;
	localparam int          HDR_MASK_LSB   = 12;

	// Present-mask bit positions.
	localparam int PM_BLOCK = 0;
	localparam int PM_WALL  = 1;
	localparam int PM_PAINT = 2;
	localparam int PM_FLAGS = 3;

	// Liquid codes above this value mean no liquid.
	localparam logic [2:0] LIQ_MAX = 3'd4;

	// Input kinds carried in tuser.
	localparam logic CMD_TABLE  = 1'b0;
	localparam logic CMD_STREAM = 1'b1;

	// Parse phases: the word that the decoder expects next.
	typedef enum logic [2:0] {
		PH_DIM    = 3'd0,
		PH_HEADER = 3'd1,
		PH_BLOCK  = 3'd2,
		PH_FX     = 3'd3,
		PH_FY     = 3'd4,
		PH_WALL   = 3'd5,
		PH_PAINT  = 3'd6,
		PH_FLAGS  = 3'd7
	} phase_t;

	// Access to the framed-block table.
	typedef struct packed {
		logic              wr_en;
		logic [TBL_AW-1:0] wr_addr;
		logic              wr_bit;
		logic              rd_en;
		logic [TBL_AW-1:0] rd_addr;
	} tbl_req_t;

	// One decoded run.
	typedef struct packed {
		logic [15:0] start_index;
		logic [12:0] run_count;
		logic [15:0] block_id;
		logic [15:0] frame_x;
		logic [15:0] frame_y;
		logic [15:0] wall_id;
		logic [15:0] paint_pair;
		logic [2:0]  liquid_kind;
		logic [2:0]  slope_kind;
		logic [9:0]  flag_bits;
		logic [3:0]  present_mask;
		logic        image_done;
	} result_t;

	// First optional word at or after a phase that the header asks for.
	// PH_DIM is returned when no further word belongs to the record.
	function automatic phase_t seek_phase(phase_t from, logic [3:0] pm);
		phase_t p;
		p = PH_DIM;
		if (from <= PH_FLAGS && pm[PM_FLAGS]) p = PH_FLAGS;
		if (from <= PH_PAINT && pm[PM_PAINT]) p = PH_PAINT;
		if (from <= PH_WALL && pm[PM_WALL]) p = PH_WALL;
		if (from <= PH_BLOCK && pm[PM_BLOCK]) p = PH_BLOCK;
		return p;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/trd_table.sv
`default_nettype none

module trd_table (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire trd_pkg::tbl_req_t req,
	output logic                  rd_bit,
	output logic                  busy
);
	import trd_pkg::*;

	logic              mem [BLOCK_TYPES];
	logic [TBL_AW:0]   clr_q;
	logic              rd_q;

	// The clearing pass runs until the counter reaches the table depth.
	assign busy = !clr_q[TBL_AW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Single write port: the clearing pass first, then table loads.
	always_ff @(posedge clk) begin
		if (busy) begin
			mem[clr_q[TBL_AW-1:0]] <= 1'b0;
		end else if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_bit;
		end
	end

	// Registered read, held until the next lookup.
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_q <= mem[req.rd_addr];
		end
	end

	assign rd_bit = rd_q;

endmodule

`default_nettype wire

// File: rtl/core/trd_parser.sv
`default_nettype none

module trd_parser (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic [15:0]     in_word,
	input  wire logic            in_framed_bit,
	output logic                 in_take,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output trd_pkg::result_t     out_res
);
	import trd_pkg::*;

	phase_t      phase_q, phase_n;
	logic [15:0] total_q, total_n;
	logic [15:0] left_q, left_n;
	logic [15:0] next_q, next_n;
	logic [15:0] hdr_q, hdr_n;
	logic [15:0] blk_q, blk_n;
	logic [15:0] fx_q, fx_n;
	logic [15:0] fy_q, fy_n;
	logic [15:0] wall_q, wall_n;
	logic [15:0] paint_q, paint_n;
	logic [15:0] flags_q, flags_n;
	logic        emit_rec, emit_zero;
	logic        framed;
	logic [15:0] prod;
	logic [12:0] want, run;
	logic [15:0] left_after;
	logic        done;
	logic [2:0]  liq;
	logic        fire;
	logic        out_valid_q;
	result_t     res_q, res_n;

	// The stage moves on when the result register is free or being drained.
	assign in_take = !out_valid_q || out_ready;
	assign fire    = in_valid && in_take;

	assign framed = in_framed_bit && ({1'b0, in_word} < 17'(BLOCK_TYPES));
	assign prod   = 16'(in_word[15:8]) * 16'(in_word[7:0]);

	// Phase sequencing and hold updates for one stream word.
	always_comb begin
		phase_n   = phase_q;
		total_n   = total_q;
		left_n    = left_q;
		next_n    = next_q;
		hdr_n     = hdr_q;
		blk_n     = blk_q;
		fx_n      = fx_q;
		fy_n      = fy_q;
		wall_n    = wall_q;
		paint_n   = paint_q;
		flags_n   = flags_q;
		emit_rec  = 1'b0;
		emit_zero = 1'b0;
		case (phase_q)
			PH_DIM: begin
				total_n = prod;
				left_n  = prod;
				next_n  = '0;
				if (prod == '0) begin
					emit_zero = 1'b1;
					phase_n   = PH_DIM;
				end else begin
					phase_n = PH_HEADER;
				end
			end
			PH_HEADER: begin
				hdr_n    = in_word;
				blk_n    = '0;
				fx_n     = '0;
				fy_n     = '0;
				wall_n   = '0;
				paint_n  = '0;
				flags_n  = '0;
				phase_n  = seek_phase(PH_BLOCK, in_word[15:HDR_MASK_LSB]);
				emit_rec = (phase_n == PH_DIM);
			end
			PH_BLOCK: begin
				blk_n = in_word;
				if (framed) begin
					phase_n = PH_FX;
				end else begin
					phase_n  = seek_phase(PH_WALL, hdr_q[15:HDR_MASK_LSB]);
					emit_rec = (phase_n == PH_DIM);
				end
			end
			PH_FX: begin
				fx_n    = in_word;
				phase_n = PH_FY;
			end
			PH_FY: begin
				fy_n     = in_word;
				phase_n  = seek_phase(PH_WALL, hdr_q[15:HDR_MASK_LSB]);
				emit_rec = (phase_n == PH_DIM);
			end
			PH_WALL: begin
				wall_n   = in_word;
				phase_n  = seek_phase(PH_PAINT, hdr_q[15:HDR_MASK_LSB]);
				emit_rec = (phase_n == PH_DIM);
			end
			PH_PAINT: begin
				paint_n  = in_word;
				phase_n  = seek_phase(PH_FLAGS, hdr_q[15:HDR_MASK_LSB]);
				emit_rec = (phase_n == PH_DIM);
			end
			PH_FLAGS: begin
				flags_n  = in_word;
				emit_rec = 1'b1;
			end
			default: begin
				phase_n = PH_DIM;
			end
		endcase

		// Run length, cut to the tiles that remain.
		want       = 13'(hdr_n & HDR_COUNT_MASK) + 13'd1;
		run        = (16'(want) < left_q) ? want : left_q[12:0];
		left_after = left_q - 16'(run);
		done       = (left_after == '0);
		if (emit_rec) begin
			left_n  = left_after;
			next_n  = next_q + 16'(run);
			phase_n = done ? PH_DIM : PH_HEADER;
		end
	end

	// Result assembly from the updated holds.
	always_comb begin
		liq = flags_n[2:0];
		if (liq > LIQ_MAX) begin
			liq = '0;
		end
		res_n              = '0;
		res_n.start_index  = next_q;
		res_n.run_count    = run;
		res_n.block_id     = blk_n;
		res_n.frame_x      = fx_n;
		res_n.frame_y      = fy_n;
		res_n.wall_id      = wall_n;
		res_n.paint_pair   = paint_n;
		res_n.liquid_kind  = liq;
		res_n.slope_kind   = flags_n[5:3];
		res_n.flag_bits    = flags_n[15:6];
		res_n.present_mask = hdr_n[15:HDR_MASK_LSB];
		res_n.image_done   = done;
		if (emit_zero) begin
			res_n            = '0;
			res_n.image_done = 1'b1;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_DIM;
			total_q     <= '0;
			left_q      <= '0;
			next_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q <= phase_n;
				total_q <= total_n;
				left_q  <= left_n;
				next_q  <= next_n;
			end
			if (in_take) begin
				out_valid_q <= fire && (emit_rec || emit_zero);
			end
		end
	end

	// Record holds and the result register.
	always_ff @(posedge clk) begin
		if (fire) begin
			hdr_q   <= hdr_n;
			blk_q   <= blk_n;
			fx_q    <= fx_n;
			fy_q    <= fy_n;
			wall_q  <= wall_n;
			paint_q <= paint_n;
			flags_q <= flags_n;
		end
		if (fire && (emit_rec || emit_zero)) begin
			res_q <= res_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	// Tiles left never exceed the grid total.
	a_left_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		left_q <= total_q)
		else $error("tiles left exceed grid total");

	// Inside an image at least one tile is still free.
	a_left_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_DIM) |-> (left_q != '0))
		else $error("image open with no tiles left");

	// A run that completes the grid sends the decoder back to the dimension word.
	a_done_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && emit_rec && done) |=> (phase_q == PH_DIM))
		else $error("grid complete but parse did not rewind");

endmodule

`default_nettype wire

// File: rtl/core/tile_record_rle_decoder.sv
`default_nettype none

// Tile record run-length decoder. One input transfer is accepted per clock while
// s_tready is high: a stream word (tuser 1) or a framed-table write (tuser 0). A
// stream word is registered and looked up in the framed-block table memory in
// the same cycle, and is decoded from the first stage once the parser can take
// it; a record's run is then registered in the result register. A finished run
// waits in the result register while the next word is taken; s_tready falls only
// while the table is cleared, or while that register is full and not drained and
// a word already waits in the first stage. After reset the table is cleared by a
// pass over all 1024 entries, one entry a cycle, during which s_tready stays low.
module tile_record_rle_decoder (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// data_word [15:0], table_index [25:16], table_bit [26], zero [31:27]
	input  wire logic [31:0]  s_tdata,
	// cmd [0]
	input  wire logic [0:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// start_index [15:0], run_count [28:16], block_id [44:29], frame_x [60:45],
	// frame_y [76:61], wall_id [92:77], paint_pair [108:93], liquid_kind [111:109],
	// slope_kind [114:112], flag_bits [124:115], zero [127:125]
	output logic [127:0]      m_tdata,
	// present_mask [3:0]
	output logic [3:0]        m_tuser,
	// image_done
	output logic              m_tlast
);
	import trd_pkg::*;

	logic        valid_s1;
	logic [15:0] word_s1;
	logic        accept;
	logic        take;
	logic        tbl_busy;
	logic        tbl_bit;
	tbl_req_t    tbl_req;
	result_t     res;

	assign s_tready = !tbl_busy && (!valid_s1 || take);
	assign accept   = s_tvalid && s_tready;

	// Table writes land at once; stream words start their lookup.
	always_comb begin
		tbl_req.wr_en   = accept && (s_tuser[0] == CMD_TABLE);
		tbl_req.wr_addr = s_tdata[16 +: TBL_AW];
		tbl_req.wr_bit  = s_tdata[26];
		tbl_req.rd_en   = accept && (s_tuser[0] == CMD_STREAM);
		tbl_req.rd_addr = s_tdata[TBL_AW-1:0];
	end

	// First stage: the stream word beside its table lookup.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= (s_tuser[0] == CMD_STREAM);
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_req.rd_en) begin
			word_s1 <= s_tdata[15:0];
		end
	end

	trd_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tbl_req),
		.rd_bit (tbl_bit),
		.busy   (tbl_busy)
	);

	trd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (valid_s1),
		.in_word       (word_s1),
		.in_framed_bit (tbl_bit),
		.in_take       (take),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_res       (res)
	);

	// Pack the result onto the master side.
	assign m_tdata = {3'b0, res.flag_bits, res.slope_kind, res.liquid_kind,
		res.paint_pair, res.wall_id, res.frame_y, res.frame_x, res.block_id,
		res.run_count, res.start_index};
	assign m_tuser = res.present_mask;
	assign m_tlast = res.image_done;

endmodule

`default_nettype wire
